// ===== rtl/core/ostb_pkg.sv =====
`default_nettype none

package ostb_pkg;

   localparam int unsigned NUM_TIMERS    = 5;
   localparam int unsigned ENTRY_IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   localparam int unsigned ACTION_W      = 3;
   localparam int unsigned TIMER_INDEX_W = 3;
   localparam int unsigned TARGET_W      = 31;
   localparam int unsigned EVENT_W       = 8;
   localparam int unsigned TIME_W        = 32;

   // request action codes; 5..7 are ignored
   typedef enum logic [ACTION_W-1:0] {
      ACT_SET       = 3'd0,
      ACT_START     = 3'd1,
      ACT_CANCEL    = 3'd2,
      ACT_CHECK     = 3'd3,
      ACT_RESET_ALL = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SET,
      OP_START,
      OP_CANCEL,
      OP_CLEAR_ALL,
      OP_EXPIRE
   } bank_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // update command from the sequencer to the entry bank
   typedef struct packed {
      bank_op_type             op;
      logic [ENTRY_IDX_W-1:0]  idx;
      logic [TARGET_W-1:0]     target;
      logic [EVENT_W-1:0]      event_id;
      logic [TIME_W-1:0]       stamp;
   } bank_cmd_type;

   // one entry as read out of the bank
   typedef struct packed {
      logic [TARGET_W-1:0] duration;
      logic [EVENT_W-1:0]  event_id;
      logic [TIME_W-1:0]   start;
      logic                running;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/ostb_req_if.sv =====
`default_nettype none

interface ostb_req_if
   import ostb_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic [ACTION_W-1:0]      action;
   logic [TIMER_INDEX_W-1:0] timer_index;
   logic [TARGET_W-1:0]      target_time;
   logic [EVENT_W-1:0]       event_id;
   logic [TIME_W-1:0]        time_now;

   modport source (
      output valid, action, timer_index, target_time, event_id, time_now,
      input  ready
   );

   modport sink (
      input  valid, action, timer_index, target_time, event_id, time_now,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/ostb_rsp_if.sv =====
`default_nettype none

interface ostb_rsp_if
   import ostb_pkg::*;
;
   logic               valid;
   logic               ready;
   logic               fired;
   logic [EVENT_W-1:0] fired_event;
   logic               last;

   modport source (
      output valid, fired, fired_event, last,
      input  ready
   );

   modport sink (
      input  valid, fired, fired_event, last,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/ostb_entry_bank.sv =====
`default_nettype none

module ostb_entry_bank
   import ostb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bank_cmd_type           cmd,
   input  wire logic [ENTRY_IDX_W-1:0] rd_idx,
   output entry_type                   rd_entry
);

   logic [TARGET_W-1:0] duration_ff [NUM_TIMERS];
   logic [EVENT_W-1:0]  event_ff    [NUM_TIMERS];
   logic [TIME_W-1:0]   start_ff    [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] running_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            duration_ff[i] <= '0;
            event_ff[i]    <= '0;
            start_ff[i]    <= '0;
         end
         running_ff <= '0;
      end else begin
         unique case (cmd.op)
            OP_NONE: begin
            end
            OP_SET: begin
               // start is cleared, running flag untouched
               duration_ff[cmd.idx] <= cmd.target;
               event_ff[cmd.idx]    <= cmd.event_id;
               start_ff[cmd.idx]    <= '0;
            end
            OP_START: begin
               start_ff[cmd.idx]   <= cmd.stamp;
               running_ff[cmd.idx] <= 1'b1;
            end
            OP_CANCEL, OP_EXPIRE: begin
               start_ff[cmd.idx]   <= '0;
               running_ff[cmd.idx] <= 1'b0;
            end
            OP_CLEAR_ALL: begin
               // running flags survive a reset-all
               for (int i = 0; i < NUM_TIMERS; i++) begin
                  duration_ff[i] <= '0;
                  event_ff[i]    <= '0;
                  start_ff[i]    <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rd_entry.duration = duration_ff[rd_idx];
      rd_entry.event_id = event_ff[rd_idx];
      rd_entry.start    = start_ff[rd_idx];
      rd_entry.running  = running_ff[rd_idx];
   end

endmodule

`default_nettype wire

// ===== rtl/core/ostb_expiry_unit.sv =====
`default_nettype none

module ostb_expiry_unit
   import ostb_pkg::*;
(
   input  wire entry_type         entry,
   input  wire logic [TIME_W-1:0] now,
   output logic                   expired
);

   logic [TIME_W-1:0] elapsed;

   // elapsed wraps modulo 2^32
   assign elapsed = now - entry.start;
   assign expired = entry.running && (elapsed >= TIME_W'(entry.duration));

endmodule

`default_nettype wire

// ===== rtl/core/ostb_sequencer.sv =====
`default_nettype none

module ostb_sequencer
   import ostb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   ostb_req_if.sink                    req_chan,
   ostb_rsp_if.source                  rsp_chan,
   input  wire logic                   expired,
   input  wire logic [EVENT_W-1:0]     cur_event,
   output logic [ENTRY_IDX_W-1:0]      scan_idx,
   output logic [TIME_W-1:0]           scan_now,
   output bank_cmd_type                bank_cmd
);

   state_type               state_ff, state_in;
   logic [ENTRY_IDX_W-1:0]  idx_ff, idx_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [EVENT_W-1:0]      pend_event_ff, pend_event_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_fired_ff, out_fired_in;
   logic [EVENT_W-1:0]      out_event_ff, out_event_in;
   logic                    out_last_ff, out_last_in;

   logic accept;
   logic slot_free;
   logic scan_last;
   logic stall;
   logic advance;
   logic idx_ok;
   logic push;
   logic push_fired;
   logic [EVENT_W-1:0] push_event;
   logic push_last;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign scan_last = (idx_ff == ENTRY_IDX_W'(NUM_TIMERS - 1));
   // a second hit needs the held one moved out first
   assign stall     = expired && pend_valid_ff && !slot_free;
   assign advance   = (state_ff == ST_SCAN) && !stall;
   assign idx_ok    = (32'(req_chan.timer_index) < NUM_TIMERS);

   assign scan_idx = idx_ff;
   assign scan_now = now_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_chan.action == ACT_CHECK) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (advance && scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      bank_cmd.op       = OP_NONE;
      bank_cmd.idx      = ENTRY_IDX_W'(req_chan.timer_index);
      bank_cmd.target   = req_chan.target_time;
      bank_cmd.event_id = req_chan.event_id;
      bank_cmd.stamp    = req_chan.time_now;
      idx_in        = idx_ff;
      now_in        = now_ff;
      pend_valid_in = pend_valid_ff;
      pend_event_in = pend_event_ff;
      push          = 1'b0;
      push_fired    = 1'b0;
      push_event    = '0;
      push_last     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_chan.action)
                  ACT_SET:       if (idx_ok) bank_cmd.op = OP_SET;
                  ACT_START:     if (idx_ok) bank_cmd.op = OP_START;
                  ACT_CANCEL:    if (idx_ok) bank_cmd.op = OP_CANCEL;
                  ACT_RESET_ALL: bank_cmd.op = OP_CLEAR_ALL;
                  ACT_CHECK: begin
                     idx_in = '0;
                     now_in = req_chan.time_now;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (advance) begin
               idx_in = ENTRY_IDX_W'(idx_ff + 1'b1);
               if (expired) begin
                  bank_cmd.op   = OP_EXPIRE;
                  bank_cmd.idx  = idx_ff;
                  pend_valid_in = 1'b1;
                  pend_event_in = cur_event;
                  // held hit is known not to be last
                  if (pend_valid_ff) begin
                     push       = 1'b1;
                     push_fired = 1'b1;
                     push_event = pend_event_ff;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               push          = 1'b1;
               push_fired    = pend_valid_ff;
               push_event    = pend_valid_ff ? pend_event_ff : '0;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_fired_in = out_fired_ff;
      out_event_in = out_event_ff;
      out_last_in  = out_last_ff;
      priority if (push) begin
         out_valid_in = 1'b1;
         out_fired_in = push_fired;
         out_event_in = push_event;
         out_last_in  = push_last;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.fired       = out_fired_ff;
   assign rsp_chan.fired_event = out_event_ff;
   assign rsp_chan.last        = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      now_ff        <= now_in;
      pend_event_ff <= pend_event_in;
      out_fired_ff  <= out_fired_in;
      out_event_ff  <= out_event_in;
      out_last_ff   <= out_last_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/one_shot_timer_bank_top.sv =====
// Set, start, cancel, reset-all and unknown requests are handled on accept; ready stays high.
// A check runs accept, then a scan of all NUM_TIMERS entries (one entry per cycle through the
// shared subtract/compare unit, except while a second hit waits on the response side), then
// finish, which waits for a free response slot.
// Synchronous active-high reset clears all entries, flags and handshake state.
`default_nettype none

module one_shot_timer_bank_top
   import ostb_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   ostb_req_if.sink   req_chan,
   ostb_rsp_if.source rsp_chan
);

   // Scan flow: the sequencer walks entries 0..NUM_TIMERS-1, the bank presents
   // the addressed entry, and the expiry unit decides if it fired. A hit is held
   // one deep so the final response of the check can carry last.

   bank_cmd_type           bank_cmd;
   entry_type              cur_entry;
   logic [ENTRY_IDX_W-1:0] scan_idx;
   logic [TIME_W-1:0]      scan_now;
   logic                   expired;

   ostb_entry_bank u_bank (
      .clock    (clock),
      .reset    (reset),
      .cmd      (bank_cmd),
      .rd_idx   (scan_idx),
      .rd_entry (cur_entry)
   );

   // the one shared compare: running and (now - start) mod 2^32 >= duration
   ostb_expiry_unit u_expiry (
      .entry   (cur_entry),
      .now     (scan_now),
      .expired (expired)
   );

   ostb_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .expired   (expired),
      .cur_event (cur_entry.event_id),
      .scan_idx  (scan_idx),
      .scan_now  (scan_now),
      .bank_cmd  (bank_cmd)
   );

   // a "nothing fired" response always closes its check with event 0
   a_nofire_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.fired) |-> (rsp_chan.last && rsp_chan.fired_event == '0))
      else $error("non-fired response without last or with nonzero event");

   // a check request closes the request side while the scan runs
   a_check_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.action == ACT_CHECK) |=> !req_chan.ready)
      else $error("request accepted during check scan");

   // expiry updates only happen during a scan
   a_expire_in_scan: assert property (@(posedge clock) disable iff (reset)
      (bank_cmd.op == OP_EXPIRE) |-> !req_chan.ready)
      else $error("entry expired outside a check");

endmodule

`default_nettype wire

// ===== tb/sv/timer_expiry_checker.sv =====
`timescale 1ns / 100ps

module timer_expiry_checker
   import ostb_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   ostb_req_if         req_mon,
   ostb_rsp_if         rsp_mon,
   output int unsigned pending,
   output int unsigned mismatches
);

   typedef struct packed {
      logic               fired;
      logic [EVENT_W-1:0] fired_event;
      logic               last;
   } expiry_type;

   logic [TARGET_W-1:0] duration_q [NUM_TIMERS];
   logic [EVENT_W-1:0]  event_q    [NUM_TIMERS];
   logic [TIME_W-1:0]   start_q    [NUM_TIMERS];
   logic                running_q  [NUM_TIMERS];
   expiry_type          expiry_fifo [$];

   task automatic clear_bank(input bit keep_running);
      for (int i = 0; i < NUM_TIMERS; i++) begin
         duration_q[i] = '0;
         event_q[i]    = '0;
         start_q[i]    = '0;
         if (!keep_running) running_q[i] = 1'b0;
      end
   endtask

   // updates the bank copy for one request and queues what a check emits
   task automatic predict_request(
      input logic [ACTION_W-1:0]      act,
      input logic [TIMER_INDEX_W-1:0] idx,
      input logic [TARGET_W-1:0]      tgt,
      input logic [EVENT_W-1:0]       ev,
      input logic [TIME_W-1:0]        now
   );
      logic [TIME_W-1:0] elapsed;
      expiry_type        hit_list [NUM_TIMERS];
      int                hits;
      hits = 0;
      case (act)
         ACT_SET: begin
            if (idx < NUM_TIMERS) begin
               duration_q[idx] = tgt;
               event_q[idx]    = ev;
               start_q[idx]    = '0;
            end
         end
         ACT_START: begin
            if (idx < NUM_TIMERS) begin
               start_q[idx]   = now;
               running_q[idx] = 1'b1;
            end
         end
         ACT_CANCEL: begin
            if (idx < NUM_TIMERS) begin
               start_q[idx]   = '0;
               running_q[idx] = 1'b0;
            end
         end
         ACT_RESET_ALL: begin
            clear_bank(1'b1);
         end
         ACT_CHECK: begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (running_q[i]) begin
                  elapsed = now - start_q[i];
                  if (elapsed >= TIME_W'(duration_q[i])) begin
                     running_q[i]  = 1'b0;
                     start_q[i]    = '0;
                     hit_list[hits] = '{fired: 1'b1, fired_event: event_q[i], last: 1'b0};
                     hits++;
                  end
               end
            end
            if (hits == 0) begin
               expiry_fifo.push_back('{fired: 1'b0, fired_event: '0, last: 1'b1});
            end else begin
               hit_list[hits-1].last = 1'b1;
               for (int k = 0; k < hits; k++) expiry_fifo.push_back(hit_list[k]);
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      expiry_type want;
      if (reset) begin
         clear_bank(1'b0);
         expiry_fifo.delete();
         mismatches = 0;
         pending <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_request(req_mon.action, req_mon.timer_index, req_mon.target_time,
                            req_mon.event_id, req_mon.time_now);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expiry_fifo.size() == 0) begin
               $error("unexpected response: fired %0d fired_event %0d last %0d",
                      rsp_mon.fired, rsp_mon.fired_event, rsp_mon.last);
               mismatches++;
            end else begin
               want = expiry_fifo.pop_front();
               if (rsp_mon.fired !== want.fired) begin
                  $error("fired: expected %0d, actual %0d", want.fired, rsp_mon.fired);
                  mismatches++;
               end
               if (rsp_mon.fired_event !== want.fired_event) begin
                  $error("fired_event: expected %0d, actual %0d",
                         want.fired_event, rsp_mon.fired_event);
                  mismatches++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_mon.last);
                  mismatches++;
               end
            end
         end
         pending <= expiry_fifo.size();
      end
   end

endmodule

// ===== tb/sv/tb_one_shot_timer_bank_top.sv =====
`timescale 1ns / 100ps

module tb_one_shot_timer_bank_top;
   import ostb_pkg::*;

   localparam int unsigned BULK_ITEMS  = 275;
   localparam int unsigned DRAIN_EVERY = 80;
   // action codes the block must ignore
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

   logic              clock = 1'b0;
   logic              reset;
   int unsigned       expected_left;
   int unsigned       error_count;
   logic [TIME_W-1:0] wall_time;
   bit                req_quiet;
   bit                rsp_quiet;

   ostb_req_if req_chan ();
   ostb_rsp_if rsp_chan ();

   one_shot_timer_bank_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predicts and compares every response; reports outstanding count and errors
   timer_expiry_checker expiry_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .pending    (expected_left),
      .mismatches (error_count)
   );

   always #5 clock = ~clock;

   // Hands one request to the block. A random idle gap comes first,
   // except during quiet stretches where requests go back to back.
   task automatic send_request(
      input logic [ACTION_W-1:0] act,
      input logic [31:0]         idx,
      input logic [31:0]         tgt,
      input logic [31:0]         ev,
      input logic [31:0]         now
   );
      int unsigned gap;
      if ($urandom_range(0, 19) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.action      <= act;
      req_chan.timer_index <= TIMER_INDEX_W'(idx);
      req_chan.target_time <= TARGET_W'(tgt);
      req_chan.event_id    <= EVENT_W'(ev);
      req_chan.time_now    <= TIME_W'(now);
      req_chan.valid       <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Holds off the sender until every predicted response has come back.
   // The checker's count is registered, so the wait does not read it straight away.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   // Response side: ready drops for a random stretch before each response,
   // with quiet stretches where it stays high.
   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) rsp_quiet = !rsp_quiet;
         stall = rsp_quiet ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   // Hard stop in case the run hangs.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int unsigned               counted;
      int unsigned               pick;
      logic [ACTION_W-1:0]       act;
      logic [TIMER_INDEX_W-1:0]  idx;
      logic [TARGET_W-1:0]       tgt;
      logic [TIME_W-1:0]         stamp;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.action      <= ACT_SET;
      req_chan.timer_index <= '0;
      req_chan.target_time <= '0;
      req_chan.event_id    <= '0;
      req_chan.time_now    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // check on an idle bank: single empty response with last set
      send_request(ACT_CHECK, 0, $urandom(), $urandom(), 32'h0);

      // entry 0: zero duration, top event; entry 4: largest duration, event 0;
      // entry 1: duration 100 started just before the time wraps
      send_request(ACT_SET, 0, 32'd0, 32'hFF, $urandom());
      send_request(ACT_SET, 4, 32'h7FFF_FFFF, 32'h00, $urandom());
      send_request(ACT_SET, 1, 32'd100, 32'h5A, $urandom());
      send_request(ACT_START, 0, $urandom(), $urandom(), 32'hFFFF_FFFF);
      send_request(ACT_START, 4, $urandom(), $urandom(), 32'h0);
      send_request(ACT_START, 1, $urandom(), $urandom(), 32'hFFFF_FFF0);

      // elapsed across the wrap: entry 0 fires, entry 1 at 96 ticks does not
      send_request(ACT_CHECK, 0, $urandom(), $urandom(), 32'h50);
      // entry 1 at exactly its target fires
      send_request(ACT_CHECK, 0, $urandom(), $urandom(), 32'h54);

      // out-of-range indexes and unknown actions change nothing
      send_request(ACT_SET, 5, 32'd1, 32'h77, $urandom());
      send_request(ACT_START, 7, $urandom(), $urandom(), $urandom());
      send_request(ACT_CANCEL, 6, $urandom(), $urandom(), $urandom());
      send_request(ACT_UNUSED_LO, 0, $urandom(), $urandom(), $urandom());
      send_request(ACT_UNUSED_HI, 4, $urandom(), $urandom(), $urandom());

      // largest duration reached exactly
      send_request(ACT_CHECK, 3, $urandom(), $urandom(), 32'h7FFF_FFFF);

      // cancelled entry 2 must stay quiet while entry 3 fires
      send_request(ACT_SET, 3, 32'd5, 32'h22, $urandom());
      send_request(ACT_START, 3, $urandom(), $urandom(), 32'd1000);
      send_request(ACT_START, 2, $urandom(), $urandom(), 32'd1000);
      send_request(ACT_CANCEL, 2, $urandom(), $urandom(), $urandom());
      send_request(ACT_CHECK, 0, $urandom(), $urandom(), 32'd1005);

      // set on a running entry clears its start but keeps it running;
      // reset-all keeps running flags, so those fire with event 0
      send_request(ACT_START, 2, $urandom(), $urandom(), 32'd9);
      send_request(ACT_SET, 2, 32'd1, 32'h33, $urandom());
      send_request(ACT_RESET_ALL, $urandom(), $urandom(), $urandom(), $urandom());
      send_request(ACT_START, 1, $urandom(), $urandom(), 32'd3);
      send_request(ACT_START, 4, $urandom(), $urandom(), 32'd0);
      // three entries expire in one check; last only on entry 4
      send_request(ACT_CHECK, 0, $urandom(), $urandom(), 32'd2);

      wait_for_drain();

      // ---- random part ----
      // Mostly set/start/check sequences against a moving wall clock so
      // short timers actually expire; a little pure noise on top.
      wall_time = $urandom();
      counted   = 0;
      while (counted < BULK_ITEMS) begin
         pick  = $urandom_range(0, 99);
         idx   = ($urandom_range(0, 9) == 0) ? TIMER_INDEX_W'($urandom_range(0, 7))
                                             : TIMER_INDEX_W'($urandom_range(0, NUM_TIMERS-1));
         stamp = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom()) : wall_time;
         case ($urandom_range(0, 9))
            0:       tgt = TARGET_W'($urandom());
            1:       tgt = TARGET_W'(31'h7FFF_FFFF - $urandom_range(0, 3));
            default: tgt = TARGET_W'($urandom_range(0, 48));
         endcase

         if (pick < 28) begin
            act = ACT_SET;
         end else if (pick < 52) begin
            act = ACT_START;
         end else if (pick < 60) begin
            act = ACT_CANCEL;
         end else if (pick < 88) begin
            act = ACT_CHECK;
            // advance time; now and then a big leap so long timers go off
            if ($urandom_range(0, 19) == 0) wall_time += $urandom();
            else wall_time += $urandom_range(0, 24);
            stamp = wall_time;
         end else if (pick < 91) begin
            act = ACT_RESET_ALL;
         end else begin
            act   = ACTION_W'($urandom_range(0, 7));
            idx   = TIMER_INDEX_W'($urandom_range(0, 7));
            tgt   = TARGET_W'($urandom());
            stamp = $urandom();
         end

         send_request(act, 32'(idx), 32'(tgt), $urandom(), stamp);

         // ignored requests do not count toward the total
         if (act <= ACT_RESET_ALL && (act >= ACT_CHECK || idx < NUM_TIMERS)) begin
            counted++;
            if (counted % DRAIN_EVERY == 0) wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (20) @(posedge clock);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
